/* design/krt_pkg.sv */
// Shared types, codes and helpers for the keyed record table.
package krt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int NAME_BYTES_DEF  = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_UPDATE = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      op_type             opcode;
      logic signed [31:0] key_id;
      logic [63:0]        name_bytes;
      logic [7:0]         age_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_id;
      logic [63:0]        found_name;
      logic [7:0]         found_age;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        name;
      logic [7:0]         age;
   } record_type;

   // Index width for a table of the given depth (at least one bit).
   function automatic int idx_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Count width: must hold the depth itself.
   function automatic int cnt_w(input int depth);
      return $clog2(depth + 1);
   endfunction

   // Keep name bytes up to the first zero byte; the last name byte is always zero.
   function automatic logic [63:0] clean_name(input logic [63:0] raw, input int nbytes);
      logic [63:0] res;
      logic        live;
      res  = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if ((b + 1 >= nbytes) || (raw[8*b +: 8] == 8'h00)) begin
            live = 1'b0;
         end
         if (live) begin
            res[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return res;
   endfunction

endpackage

/* design/krt_mem.sv */
// Record store: one write port, one registered read port.
module krt_mem #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [krt_pkg::idx_w(TABLE_DEPTH)-1:0]        wr_addr,
   input  krt_pkg::record_type                           wr_data,
   input  logic [krt_pkg::idx_w(TABLE_DEPTH)-1:0]        rd_addr,
   output krt_pkg::record_type                           rd_data_ff
);
   import krt_pkg::*;

   record_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

/* design/krt_seq.sv */
// Operation sequencer: takes one item, scans the store with a single key comparator.
module krt_seq #(
   parameter int TABLE_DEPTH = 16,
   parameter int NAME_BYTES  = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  krt_pkg::req_type                              req_data,
   input  logic                                          rsp_free,
   output logic                                          done,
   output krt_pkg::rsp_type                              result,
   output logic                                          mem_we,
   output logic [krt_pkg::idx_w(TABLE_DEPTH)-1:0]        mem_waddr,
   output krt_pkg::record_type                           mem_wdata,
   output logic [krt_pkg::idx_w(TABLE_DEPTH)-1:0]        mem_raddr,
   input  krt_pkg::record_type                           mem_rdata
);
   import krt_pkg::*;

   localparam int IDX_W = idx_w(TABLE_DEPTH);
   localparam int CNT_W = cnt_w(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_MOVE = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   op_type             op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic [63:0]        name_ff, name_in;
   logic [7:0]         age_ff, age_in;
   rsp_type            res_ff, res_in;

   logic               accept;
   logic               hit;
   logic [CNT_W-1:0]   last_cnt;
   logic [IDX_W-1:0]   last_idx;
   logic [63:0]        clean;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign hit       = (mem_rdata.key == key_ff);
   assign last_cnt  = count_ff - CNT_W'(1);
   assign last_idx  = last_cnt[IDX_W-1:0];
   assign clean     = clean_name(req_data.name_bytes, NAME_BYTES);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      name_in   = name_ff;
      age_in    = age_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = mem_rdata;
      mem_raddr = '0;
      done      = 1'b0;
      result    = res_ff;
      result.entry_count = 5'(count_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_data.opcode;
               key_in  = req_data.key_id;
               name_in = clean;
               age_in  = req_data.age_value;
               res_in  = '0;
               state_in = S_RESP;
               case (req_data.opcode)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[IDX_W-1:0];
                        mem_wdata = '{key: req_data.key_id, name: clean,
                                      age: req_data.age_value};
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_MISSING;
                     end else begin
                        idx_in    = '0;
                        mem_raddr = '0;
                        state_in  = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               state_in = S_RESP;
               case (op_ff)
                  OP_READ: begin
                     res_in.found_id   = mem_rdata.key;
                     res_in.found_name = mem_rdata.name;
                     res_in.found_age  = mem_rdata.age;
                  end
                  OP_UPDATE: begin
                     mem_we    = 1'b1;
                     mem_waddr = idx_ff;
                     mem_wdata = '{key: mem_rdata.key, name: name_ff, age: age_ff};
                  end
                  default: begin
                     // delete: fetch the last entry to fill the hole
                     mem_raddr = last_idx;
                     state_in  = S_MOVE;
                  end
               endcase
            end else if (idx_ff == last_idx) begin
               res_in.status = ST_MISSING;
               state_in      = S_RESP;
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               mem_raddr = idx_ff + IDX_W'(1);
            end
         end
         S_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = mem_rdata;
            count_in  = last_cnt;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      name_ff <= name_in;
      age_ff  <= age_in;
      res_ff  <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("record count above table depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index beyond record count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_RESP) |=> $stable(count_ff))
      else $error("record count changed outside insert or delete");

endmodule

/* design/keyed_record_table.sv */
// Keyed record table: linear-search key/value store with insert, read, update, delete.
// Insert, or insert on a full table, goes from accept straight to the result; read,
// update and delete scan entries 0..count-1 in order, a delete hit then moves the last
// entry into the hole, and a missing key scans every entry (none on an empty table).
// One item at a time: the next is taken once the result is registered, later under rsp_stall.
// Reset clears the record count and the sequencer; stored records are left as they are.
module keyed_record_table #(
   parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
   parameter int NAME_BYTES  = krt_pkg::NAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  krt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output krt_pkg::rsp_type rsp_data
);
   import krt_pkg::*;

   localparam int IDX_W = idx_w(TABLE_DEPTH);

   // record store ports
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;
   record_type       mem_wdata;
   record_type       mem_rdata;

   // result hand-off from the sequencer
   logic             done;
   logic             rsp_free;
   rsp_type          result;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // The sequencer drives one key comparison per cycle against the store's
   // registered read data, walking entries 0..count-1 in order.
   krt_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NAME_BYTES  (NAME_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .done      (done),
      .result    (result),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   krt_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_data    (mem_wdata),
      .rd_addr    (mem_raddr),
      .rd_data_ff (mem_rdata)
   );

   // The result slot is free when empty or being taken this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         // load the finished item
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         // drop the item once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* verif/krt_checker.sv */
// Checker for the keyed record table: tracks the table contents and compares every result.
`timescale 1ns / 100ps

module krt_checker #(
   parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
   parameter int NAME_BYTES  = krt_pkg::NAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  krt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  krt_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count,
   output int               checked_count,
   output int               full_count
);
   import krt_pkg::*;

   logic signed [31:0] shadow_keys [TABLE_DEPTH];
   logic [63:0]        shadow_names [TABLE_DEPTH];
   logic [7:0]         shadow_ages [TABLE_DEPTH];
   int                 shadow_count = 0;
   rsp_type            answers_due [$];
   rsp_type            want;

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
      full_count    = 0;
   end

   // Keep name bytes up to the first zero; the top name byte never survives.
   function automatic logic [63:0] stored_name(input logic [63:0] raw);
      logic [63:0] kept;
      kept = '0;
      for (int b = 0; (b < NAME_BYTES - 1) && (b < 8); b++) begin
         if (raw[8*b +: 8] == 8'h00) break;
         kept[8*b +: 8] = raw[8*b +: 8];
      end
      return kept;
   endfunction

   // Apply one operation to the shadow table and return the answer it earns.
   function automatic rsp_type apply_operation(input req_type op_item);
      rsp_type     answer;
      int          hit;
      int          last;
      logic [63:0] name_kept;
      answer    = '0;
      hit       = -1;
      name_kept = stored_name(op_item.name_bytes);
      if (op_item.opcode != OP_INSERT) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == op_item.key_id) begin
               hit = i;
               break;
            end
         end
      end
      if (op_item.opcode == OP_INSERT) begin
         if (shadow_count >= TABLE_DEPTH) begin
            answer.status = ST_FULL;
            full_count++;
         end else begin
            shadow_keys[shadow_count]  = op_item.key_id;
            shadow_names[shadow_count] = name_kept;
            shadow_ages[shadow_count]  = op_item.age_value;
            shadow_count++;
         end
      end else if (hit < 0) begin
         answer.status = ST_MISSING;
      end else if (op_item.opcode == OP_READ) begin
         answer.found_id   = shadow_keys[hit];
         answer.found_name = shadow_names[hit];
         answer.found_age  = shadow_ages[hit];
      end else if (op_item.opcode == OP_UPDATE) begin
         shadow_names[hit] = name_kept;
         shadow_ages[hit]  = op_item.age_value;
      end else begin
         // Fill the hole with the last entry, then shrink.
         last              = shadow_count - 1;
         shadow_keys[hit]  = shadow_keys[last];
         shadow_names[hit] = shadow_names[last];
         shadow_ages[hit]  = shadow_ages[last];
         shadow_count      = last;
      end
      answer.entry_count = 5'(shadow_count);
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("result item with no expectation waiting: %h", rsp_data);
               error_count++;
            end else begin
               want = answers_due.pop_front();
               checked_count++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.found_id !== want.found_id) begin
                  $error("found_id: expected %0d, got %0d", want.found_id, rsp_data.found_id);
                  error_count++;
               end
               if (rsp_data.found_name !== want.found_name) begin
                  $error("found_name: expected %h, got %h",
                         want.found_name, rsp_data.found_name);
                  error_count++;
               end
               if (rsp_data.found_age !== want.found_age) begin
                  $error("found_age: expected %0d, got %0d", want.found_age, rsp_data.found_age);
                  error_count++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_data.entry_count);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            answers_due.push_back(apply_operation(req_data));
         end
      end
      pending_count <= answers_due.size();
   end

endmodule

/* verif/keyed_record_table_test.sv */
// Top of the keyed record table testbench: clock, reset, stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module keyed_record_table_test;
   import krt_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int RANDOM_ITEMS = 1380;
   localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
   localparam int HOLD_AT      = 450;   // random item count that starts the hold-off
   localparam int DRAIN_AT     = 900;   // random item count that drains the block
   localparam int KEY_POOL     = 24;    // more keys than slots, so misses and fills both occur
   localparam int TAIL_CYCLES  = 40;    // longest search plus margin

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] KEY_NEG = -32'sd1;

   logic    clock        = 1'b0;
   logic    reset        = 1'b1;
   logic    req_valid    = 1'b0;
   logic    req_stall;
   req_type req_data     = '0;
   logic    rsp_valid;
   logic    rsp_stall    = 1'b0;
   rsp_type rsp_data;
   logic    hold_trigger = 1'b0;

   int error_count;
   int pending_count;
   int checked_count;
   int full_count;
   int cycle_count = 0;
   int op_sent [4] = '{0, 0, 0, 0};

   logic signed [31:0] key_pool [KEY_POOL];

   always #10 clock = ~clock;

   keyed_record_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   krt_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .full_count    (full_count)
   );

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: switch between free flow, random stalls and a fixed duty pattern,
   // and hold off once for a long stretch when the sender asks for it.
   int   hold_left  = 0;
   int   phase_left = 0;
   int   phase_kind = 0;
   logic hold_taken = 1'b0;

   always @(posedge clock) begin
      if (hold_trigger && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            phase_kind = $urandom_range(0, 2);
            phase_left = $urandom_range(8, 120);
         end
         phase_left--;
         case (phase_kind)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 99) < 45);
            end
            default: begin
               rsp_stall <= ((phase_left % 4) == 0);
            end
         endcase
      end
   end

   // Present one item and hold it until the block takes it. Valid stays high on
   // return so a following item goes out back to back.
   task automatic offer(input op_type op, input logic signed [31:0] key,
                        input logic [63:0] name, input logic [7:0] age);
      req_type op_item;
      op_item.opcode     = op;
      op_item.key_id     = key;
      op_item.name_bytes = name;
      op_item.age_value  = age;
      req_valid <= 1'b1;
      req_data  <= op_item;
      op_sent[int'(op)]++;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid for a gap of the given number of cycles.
   task automatic pause(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Mostly pool keys so searches hit; now and then a fresh key that misses.
   function automatic logic signed [31:0] pick_key();
      if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, KEY_POOL - 1)];
      return $urandom;
   endfunction

   // Random bytes, often with an embedded zero, sometimes all ones or all zero.
   function automatic logic [63:0] pick_name();
      logic [63:0] name;
      int          roll;
      name = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         name[8*$urandom_range(0, 7) +: 8] = 8'h00;
      end else if (roll < 40) begin
         name = '1;
      end else if (roll < 43) begin
         name = '0;
      end
      return name;
   endfunction

   // Bias the operation mix: fill the table, drain it, or keep it balanced.
   function automatic op_type pick_op(input int mode);
      int roll;
      int ins_w;
      int rd_w;
      int up_w;
      roll = $urandom_range(0, 99);
      case (mode)
         0: begin
            ins_w = 55; rd_w = 20; up_w = 12;
         end
         1: begin
            ins_w = 15; rd_w = 25; up_w = 15;
         end
         default: begin
            ins_w = 30; rd_w = 25; up_w = 20;
         end
      endcase
      if (roll < ins_w) return OP_INSERT;
      if (roll < ins_w + rd_w) return OP_READ;
      if (roll < ins_w + rd_w + up_w) return OP_UPDATE;
      return OP_DELETE;
   endfunction

   initial begin
      logic signed [31:0] last_key;
      int                 sent;
      int                 burst;
      int                 mode;
      int                 steady_left;

      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = KEY_NEG;
      key_pool[3] = '0;
      for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: searches must miss.
      offer(OP_READ, '0, '0, '0);
      offer(OP_DELETE, KEY_MAX, '0, '0);
      // Key and name extremes; a zero byte mid-name cuts the rest off.
      offer(OP_INSERT, KEY_MIN, '1, 8'hFF);
      offer(OP_INSERT, KEY_MAX, '0, 8'h00);
      offer(OP_INSERT, KEY_NEG, 64'h4746_4544_0043_4241, 8'd7);
      // Duplicate key: searches must land on the first copy.
      offer(OP_INSERT, KEY_NEG, 64'h0102_0304_0506_0708, 8'd9);
      offer(OP_READ, KEY_NEG, '0, '0);
      offer(OP_UPDATE, KEY_NEG, 64'h5A5A_5A5A_5A5A_5A00, 8'h80);
      offer(OP_READ, KEY_NEG, '0, '0);
      // Delete slot 0: the last entry (second duplicate) moves into it.
      offer(OP_DELETE, KEY_MIN, '0, '0);
      offer(OP_READ, KEY_NEG, '0, '0);
      // Fill to capacity, overflow once, then search and delete the deepest entry.
      last_key = '0;
      for (int i = 0; i < 13; i++) begin
         last_key = $urandom;
         offer(OP_INSERT, last_key, pick_name(), 8'($urandom));
      end
      offer(OP_INSERT, KEY_MIN, '1, 8'hFF);
      offer(OP_READ, last_key, '0, '0);
      offer(OP_DELETE, last_key, '0, '0);
      drain();

      // Random bursts with random gaps; some bursts run with no gaps at all.
      sent        = 0;
      steady_left = 0;
      while (sent < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 2);
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            offer(pick_op(mode), pick_key(), pick_name(), 8'($urandom));
            sent++;
            if (sent == HOLD_AT) begin
               // Keep offering while the receiver holds off, so the input backs up.
               hold_trigger <= 1'b1;
               steady_left = 40;
            end
            if (sent == DRAIN_AT) drain();
            if (steady_left > 0) steady_left--;
         end
         if (steady_left == 0 && $urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d inserts, %0d reads, %0d updates, %0d deletes.",
               op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3],
               op_sent[0], op_sent[1], op_sent[2], op_sent[3]);
      $display("Compared %0d results; table overflowed %0d times; one %0d-cycle hold-off.",
               checked_count, full_count, LONG_HOLD);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
design/krt_pkg.sv
design/krt_mem.sv
design/krt_seq.sv
design/keyed_record_table.sv
verif/krt_checker.sv
verif/keyed_record_table_test.sv
